@@ rtl/gbp_pkg.sv @@
// shared constants, codes and control structs of the gshare branch predictor
package gbp_pkg;

  // table geometry
  localparam int MAX_HISTORY_BITS = 13;
  localparam int IDX_W            = MAX_HISTORY_BITS;
  localparam int TABLE_DEPTH      = 1 << MAX_HISTORY_BITS;
  localparam int CNT_W            = 2;
  localparam logic [CNT_W-1:0] CNT_RESET = 2'd1;
  localparam logic [CNT_W-1:0] CNT_MAX   = 2'd3;
  localparam logic [CNT_W-1:0] CNT_MIN   = 2'd0;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIST = 2'd1;

  // predictor modes
  localparam int MODE_W = 2;
  localparam logic [MODE_W-1:0] MODE_STATIC = 2'd0;
  localparam logic [MODE_W-1:0] MODE_GSHARE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RESET  = MODE_GSHARE;

  localparam int HB_W = 4;
  localparam logic [HB_W-1:0] HB_RESET = 4'd13;

  // opcodes
  localparam logic OP_PREDICT = 1'b0;
  localparam logic OP_TRAIN   = 1'b1;

  // stream widths
  localparam int ADDR_W     = 32;
  localparam int S_TDATA_W  = 40;
  localparam int S_TUSER_W  = 1;
  localparam int M_TDATA_W  = 8;

  // controller to datapath
  typedef struct packed {
    logic clear;   // write reset value at clear address
    logic load;    // capture input transaction
    logic read;    // issue counter read
    logic update;  // resolve prediction, write back, load output
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;   // clear pass at final entry
    logic out_stall;  // output register full and not taken
  } dp_status_t;

endpackage

@@ rtl/gbp_ram.sv @@
// generic single-port-write, registered-read ram
module gbp_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, holds when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/gbp_ctrl.sv @@
// controller state machine: table clear, accept, read, update
module gbp_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  gbp_pkg::dp_status_t    status,
  output gbp_pkg::ctrl_cmd_t     cmd
);

  localparam logic [1:0] ST_CLEAR  = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_READ   = 2'd2;
  localparam logic [1:0] ST_UPDATE = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (status.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        cmd.read   = 1'b1;
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (!status.out_stall) begin
          cmd.update = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  // reset always starts a clear pass
  a_reset_clear: assert property (@(posedge clk) rst |=> state == ST_CLEAR)
    else $error("reset did not start table clear");

  // an accepted transaction is read on the next cycle
  a_accept_read: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == ST_READ && cmd.read))
    else $error("accepted transaction not followed by a read");

  // a read is always followed by the update stage
  a_read_update: assert property (@(posedge clk) disable iff (rst)
    cmd.read |=> state == ST_UPDATE)
    else $error("read not followed by update");

endmodule

@@ rtl/gbp_dp.sv @@
// datapath: config registers, history, counter table, output register
module gbp_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [gbp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gbp_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic [gbp_pkg::S_TDATA_W-1:0]     s_tdata,
  input  logic [gbp_pkg::S_TUSER_W-1:0]     s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [gbp_pkg::M_TDATA_W-1:0]     m_tdata,
  input  gbp_pkg::ctrl_cmd_t                cmd,
  output gbp_pkg::dp_status_t               status
);

  logic [gbp_pkg::MODE_W-1:0] predictor_mode;
  logic [gbp_pkg::HB_W-1:0]   history_bits;
  logic [gbp_pkg::IDX_W-1:0]  global_history;
  logic [gbp_pkg::IDX_W-1:0]  clr_addr;
  logic                       op_q;
  logic                       outcome_q;
  logic [gbp_pkg::IDX_W-1:0]  idx_q;
  logic                       out_valid;
  logic                       out_pred;

  logic [gbp_pkg::HB_W-1:0]   hb_sat;
  logic [gbp_pkg::IDX_W-1:0]  idx_mask;
  logic [gbp_pkg::IDX_W-1:0]  in_addr;
  logic [gbp_pkg::CNT_W-1:0]  ctr;
  logic [gbp_pkg::CNT_W-1:0]  ctr_next;
  logic                       train_en;
  logic                       pred;
  logic                       ram_we;
  logic [gbp_pkg::IDX_W-1:0]  ram_waddr;
  logic [gbp_pkg::CNT_W-1:0]  ram_wdata;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      predictor_mode <= gbp_pkg::MODE_RESET;
      history_bits   <= gbp_pkg::HB_RESET;
    end else if (cfg_we) begin
      if (cfg_index == gbp_pkg::REG_MODE) begin
        predictor_mode <= cfg_data[gbp_pkg::MODE_W-1:0];
      end else if (cfg_index == gbp_pkg::REG_HIST) begin
        history_bits <= cfg_data[gbp_pkg::HB_W-1:0];
      end
    end
  end

  // index mask from saturated history length
  always_comb begin
    if (int'(history_bits) > gbp_pkg::MAX_HISTORY_BITS) begin
      hb_sat = gbp_pkg::HB_W'(gbp_pkg::MAX_HISTORY_BITS);
    end else begin
      hb_sat = history_bits;
    end
    idx_mask = ~({gbp_pkg::IDX_W{1'b1}} << hb_sat);
  end

  assign in_addr = s_tdata[gbp_pkg::IDX_W-1:0];

  // clear pass address
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear) begin
      clr_addr <= clr_addr + gbp_pkg::IDX_W'(1);
    end
  end

  assign status.clr_last = (clr_addr == {gbp_pkg::IDX_W{1'b1}});

  // capture transaction and form table index
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q      <= s_tuser[0];
      outcome_q <= s_tdata[gbp_pkg::ADDR_W];
      idx_q     <= (in_addr ^ global_history) & idx_mask;
    end
  end

  // prediction and saturating counter update
  assign train_en = (predictor_mode == gbp_pkg::MODE_GSHARE) && (op_q == gbp_pkg::OP_TRAIN);

  always_comb begin
    if (predictor_mode == gbp_pkg::MODE_STATIC) begin
      pred = 1'b1;
    end else if (predictor_mode == gbp_pkg::MODE_GSHARE) begin
      pred = ctr[gbp_pkg::CNT_W-1];
    end else begin
      pred = 1'b0;
    end
    ctr_next = ctr;
    if (outcome_q) begin
      if (ctr != gbp_pkg::CNT_MAX) begin
        ctr_next = ctr + gbp_pkg::CNT_W'(1);
      end
    end else begin
      if (ctr != gbp_pkg::CNT_MIN) begin
        ctr_next = ctr - gbp_pkg::CNT_W'(1);
      end
    end
  end

  // table write port selection
  assign ram_we    = cmd.clear || (cmd.update && train_en);
  assign ram_waddr = cmd.clear ? clr_addr : idx_q;
  assign ram_wdata = cmd.clear ? gbp_pkg::CNT_RESET : ctr_next;

  gbp_ram #(
    .WIDTH (gbp_pkg::CNT_W),
    .DEPTH (gbp_pkg::TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.read),
    .raddr (idx_q),
    .rdata (ctr)
  );

  // global history shift on training
  always_ff @(posedge clk) begin
    if (rst) begin
      global_history <= '0;
    end else if (cmd.update && train_en) begin
      global_history <= (global_history << 1) | gbp_pkg::IDX_W'(outcome_q);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.update) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      out_pred <= pred;
    end
  end

  assign status.out_stall = out_valid && !m_tready;
  assign m_tvalid = out_valid;
  assign m_tdata  = {{(gbp_pkg::M_TDATA_W-1){1'b0}}, out_pred};

  // history only moves on a gshare training update
  a_hist_hold: assert property (@(posedge clk) disable iff (rst)
    !(cmd.update && train_en) |=> $stable(global_history))
    else $error("history changed without a training update");

  // no update is issued over a waiting result
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.update |-> !status.out_stall)
    else $error("update overwrote an untaken result");

  // every update presents a result on the next cycle
  a_update_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.update |=> m_tvalid)
    else $error("update did not present a result");

endmodule

@@ rtl/gshare_branch_predictor_top.sv @@
// top level of the gshare branch predictor with 2-bit counters
//
//  channel  | direction | transaction when        | content
//  ---------+-----------+-------------------------+------------------------------------
//  s_*      | in        | s_tvalid && s_tready    | predict or train request
//  m_*      | out       | m_tvalid && m_tready    | predicted direction
//  cfg_*    | in        | cfg_we                  | register write, 0 mode, 1 history bits
//
// each request passes three steps: accept, counter table read, resolve and write back;
// the read step is set by the registered read of the single counter table ram.
// after reset a clear pass over the 8192 entries writes weakly not taken into every entry,
// during which s_tready stays low; configuration writes are taken at any time.
// a result waiting on m_tready does not block the next accept, only its update.
module gshare_branch_predictor_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [gbp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gbp_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // [31:0] branch_address, [32] taken_outcome, [39:33] zero
  input  logic [gbp_pkg::S_TDATA_W-1:0]     s_tdata,
  // [0] opcode
  input  logic [gbp_pkg::S_TUSER_W-1:0]     s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [0] predict_taken, [7:1] zero
  output logic [gbp_pkg::M_TDATA_W-1:0]     m_tdata
);

  gbp_pkg::ctrl_cmd_t  cmd;
  gbp_pkg::dp_status_t status;

  // sequencing
  gbp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // table, history and output
  gbp_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

@@ verif/gshare_branch_predictor_top_tb.sv @@
// self-checking testbench for the gshare branch predictor top level
module gshare_branch_predictor_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gbp_pkg::*;

  // register indexes with no register behind them, and the modes without a name in the package
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
  localparam logic [MODE_W-1:0]    MODE_OFF    = 2'd2;
  localparam logic [MODE_W-1:0]    MODE_OFF_B  = 2'd3;

  typedef struct packed {
    logic              op;
    logic [ADDR_W-1:0] addr;
    logic              outcome;
  } branch_req_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [S_TDATA_W-1:0]  s_tdata = '0;   // [31:0] branch_address, [32] taken_outcome, rest zero
  logic [S_TUSER_W-1:0]  s_tuser = '0;   // [0] opcode
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_tdata;        // [0] predict_taken, rest zero

  gshare_branch_predictor_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  // predictor copy kept by the testbench
  logic [MODE_W-1:0]        dir_mode;
  logic [HB_W-1:0]          dir_hbits;
  logic [IDX_W-1:0]         dir_history;
  logic [CNT_W-1:0]         dir_table [TABLE_DEPTH];

  branch_req_t pending_reqs[$];
  logic        expected_dir[$];
  int          fail_count = 0;

  // clock
  initial begin
    forever #1 clk = ~clk;
  end

  // hard limit on the run
  initial begin
    #2ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic void reset_predictor();
    dir_mode    = MODE_RESET;
    dir_hbits   = HB_RESET;
    dir_history = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) dir_table[i] = CNT_RESET;
  endfunction

  // direction before any update; trains table and history in gshare mode only
  function automatic logic gshare_lookup(logic op, logic [ADDR_W-1:0] addr, logic outcome);
    logic [HB_W-1:0]  n;
    logic [IDX_W-1:0] mask;
    logic [IDX_W-1:0] idx;
    logic [CNT_W-1:0] ctr;
    logic             dir;
    n    = (dir_hbits > MAX_HISTORY_BITS) ? HB_W'(MAX_HISTORY_BITS) : dir_hbits;
    mask = IDX_W'((32'd1 << n) - 32'd1);
    dir  = 1'b0;
    if (dir_mode == MODE_STATIC) begin
      dir = 1'b1;
    end else if (dir_mode == MODE_GSHARE) begin
      idx = (addr[IDX_W-1:0] ^ dir_history) & mask;
      ctr = dir_table[idx];
      dir = ctr[CNT_W-1];
      if (op == OP_TRAIN) begin
        if (outcome && ctr != CNT_MAX) ctr = ctr + 1'b1;
        else if (!outcome && ctr != CNT_MIN) ctr = ctr - 1'b1;
        dir_table[idx] = ctr;
        dir_history = {dir_history[IDX_W-2:0], outcome};
      end
    end
    return dir;
  endfunction

  // request driver: bursts of random length with random gaps
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin : drive_proc
    branch_req_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        s_tvalid <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        nxt = pending_reqs.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, nxt.outcome, nxt.addr};
        s_tuser  <= nxt.op;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver stall pattern, style redrawn whenever rx_cycle[5:0] is zero
  logic [15:0] rx_cycle = '0;
  logic [1:0]  rx_style = '0;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      rx_cycle <= rx_cycle + 1'b1;
      if (rx_cycle[5:0] == 6'd0) rx_style <= 2'($urandom_range(0, 3));
      case (rx_style)
        2'd0: m_tready <= 1'b1;
        2'd1: m_tready <= 1'($urandom_range(0, 1));
        2'd2: m_tready <= ($urandom_range(0, 3) == 0);
        default: m_tready <= rx_cycle[2];
      endcase
    end
  end

  // monitor: check results, then predict for newly accepted requests
  always @(posedge clk) begin : check_proc
    logic expd;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (expected_dir.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: result with nothing expected, m_tdata %02h", $realtime, m_tdata);
          fail_count++;
        end else begin
          expd = expected_dir.pop_front();
          if (m_tdata !== {7'b0, expd}) begin
            if (fail_count < 10)
              $display("%0t: predict_taken expected %0b, m_tdata got %02h",
                       $realtime, expd, m_tdata);
            fail_count++;
          end
        end
      end
      if (s_tvalid && s_tready)
        expected_dir.push_back(gshare_lookup(s_tuser[0], s_tdata[ADDR_W-1:0], s_tdata[ADDR_W]));
    end
  end

  task automatic queue_branch(logic op, logic [ADDR_W-1:0] addr, logic outcome);
    branch_req_t r;
    r.op = op;
    r.addr = addr;
    r.outcome = outcome;
    pending_reqs.push_back(r);
  endtask

  // wait until every request is sent and every result has come back
  task automatic drain();
    @(negedge clk);
    while (pending_reqs.size() != 0 || s_tvalid || expected_dir.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    if (idx == REG_MODE) dir_mode = data[MODE_W-1:0];
    else if (idx == REG_HIST) dir_hbits = data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // one phase of random traffic: loops, biased hot branches, replays and noise
  task automatic fill_random_phase(int n_items);
    logic [ADDR_W-1:0] hot [8];
    logic [ADDR_W-1:0] a;
    int count;
    int kind;
    int period;
    int iters;
    logic bias;
    count = 0;
    foreach (hot[i]) hot[i] = $urandom();
    while (count < n_items) begin
      kind = $urandom_range(0, 9);
      if (kind <= 3) begin
        // loop branch with a fixed trip count
        a = ($urandom_range(0, 1) == 0) ? hot[$urandom_range(0, 7)] : $urandom();
        period = $urandom_range(1, 6);
        iters = $urandom_range(period, 4 * period);
        for (int i = 0; i < iters; i++) begin
          if ($urandom_range(0, 2) == 0) begin
            queue_branch(OP_PREDICT, a, 1'($urandom_range(0, 1)));
            count++;
          end
          queue_branch(OP_TRAIN, a, (i % period) != period - 1);
          count++;
        end
      end else if (kind <= 6) begin
        // strongly biased branch from the hot set
        a = hot[$urandom_range(0, 7)];
        bias = 1'($urandom_range(0, 1));
        iters = $urandom_range(2, 12);
        for (int i = 0; i < iters; i++) begin
          queue_branch(OP_TRAIN, a, ($urandom_range(0, 6) == 0) ? !bias : bias);
          count++;
        end
      end else if (kind == 7) begin
        // predictions only over the hot set
        iters = $urandom_range(2, 8);
        for (int i = 0; i < iters; i++) begin
          queue_branch(OP_PREDICT, hot[$urandom_range(0, 7)], 1'($urandom_range(0, 1)));
          count++;
        end
      end else begin
        queue_branch(1'($urandom_range(0, 1)), $urandom(), 1'($urandom_range(0, 1)));
        count++;
      end
    end
  endtask

  // random configuration for one phase
  task automatic random_config(int phase);
    logic [MODE_W-1:0] mode;
    logic [HB_W-1:0]   hb;
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) mode = MODE_GSHARE;
    else if (r < 8) mode = MODE_STATIC;
    else if (r == 8) mode = MODE_OFF;
    else mode = MODE_OFF_B;
    case ($urandom_range(0, 7))
      0: hb = 4'd0;
      1: hb = 4'd1;
      2: hb = HB_RESET;
      3: hb = 4'd15;
      default: hb = 4'($urandom_range(0, 15));
    endcase
    if (phase == 0) begin
      mode = MODE_GSHARE;
      hb = HB_RESET;
    end else if (phase == 1) begin
      mode = MODE_GSHARE;
      hb = 4'd1;
    end
    write_reg(REG_MODE, {2'($urandom_range(0, 3)), mode});
    write_reg(REG_HIST, hb);
    if ($urandom_range(0, 3) == 0)
      write_reg(($urandom_range(0, 1) == 0) ? REG_SPARE_A : REG_SPARE_B, 4'($urandom_range(0, 15)));
  endtask

  // main sequence
  initial begin
    reset_predictor();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset configuration: history mixing and the weak reset counters
    queue_branch(OP_PREDICT, 32'h0000_0000, 1'b1);
    queue_branch(OP_TRAIN,   32'h0000_0000, 1'b1);
    queue_branch(OP_PREDICT, 32'h0000_0001, 1'b0);
    queue_branch(OP_TRAIN,   32'hFFFF_FFFF, 1'b0);
    queue_branch(OP_TRAIN,   32'h8000_0002, 1'b1);
    queue_branch(OP_PREDICT, 32'h5555_5555, 1'b1);
    queue_branch(OP_PREDICT, 32'hAAAA_AAAA, 1'b0);
    drain();

    // zero-width index: entry 0 saturates at both ends
    write_reg(REG_HIST, 4'd0);
    for (int i = 0; i < 4; i++) queue_branch(OP_TRAIN, 32'hFFFF_FFFF, 1'b0);
    queue_branch(OP_PREDICT, 32'h1234_5678, 1'b1);
    for (int i = 0; i < 4; i++) queue_branch(OP_TRAIN, 32'h0000_1FFF, 1'b1);
    queue_branch(OP_PREDICT, 32'h0000_0000, 1'b0);
    drain();

    // oversized history count clamps to the table width
    write_reg(REG_HIST, 4'd15);
    queue_branch(OP_TRAIN,   32'hFFFF_E000, 1'b1);
    queue_branch(OP_PREDICT, 32'hFFFF_FFFF, 1'b0);
    drain();

    // static mode, upper data bits of the mode write dropped
    write_reg(REG_MODE, {2'b01, MODE_STATIC});
    queue_branch(OP_TRAIN,   32'h0000_0004, 1'b0);
    queue_branch(OP_PREDICT, 32'h0000_0004, 1'b0);
    drain();

    // unimplemented modes never train
    write_reg(REG_MODE, {2'b00, MODE_OFF});
    queue_branch(OP_TRAIN,   32'h0000_0008, 1'b1);
    queue_branch(OP_PREDICT, 32'h0000_0008, 1'b1);
    drain();
    write_reg(REG_MODE, {2'b11, MODE_OFF_B});
    write_reg(REG_SPARE_A, 4'hF);
    write_reg(REG_SPARE_B, 4'h0);
    queue_branch(OP_TRAIN,   32'hFFFF_FFFF, 1'b1);
    queue_branch(OP_PREDICT, 32'h0000_0000, 1'b1);
    drain();

    // random phases
    for (int p = 0; p < 10; p++) begin
      random_config(p);
      fill_random_phase(150);
      drain();
    end

    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/gbp_pkg.sv
rtl/gbp_ram.sv
rtl/gbp_ctrl.sv
rtl/gbp_dp.sv
rtl/gshare_branch_predictor_top.sv
verif/gshare_branch_predictor_top_tb.sv
